[sv/iwrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse wavelet row synthesis package
// Shared types, filter taps and the per-column synthesis arithmetic.
// ----------------------------------------------------------------------------
package iwrs_pkg;

  // Default and sizing constants.
  localparam int unsigned MaxRowPairsDefault = 4096;
  localparam int unsigned RowWidthW          = 13;
  localparam int unsigned MinRowPairs        = 4;
  localparam int unsigned CoeffW             = 16;
  localparam int unsigned ClampBits          = 14;
  localparam int unsigned ExtW               = 24;
  localparam int unsigned AddrW              = 4;
  localparam int unsigned DataW              = 32;
  localparam int unsigned FifoDepth          = 4;
  localparam int unsigned FifoPtrW           = 2;
  localparam int unsigned FifoCntW           = 3;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_ROW_HALF_WIDTH = 2'd0,
    REG_DESCALE_SHIFT  = 2'd1,
    REG_CLAMP_ENABLE   = 2'd2
  } cfg_reg_e;

  // Position of the column pair within the row.
  typedef enum logic [1:0] {
    MODE_MID   = 2'd0,
    MODE_FIRST = 2'd1,
    MODE_LAST  = 2'd2
  } mode_e;

  // One input item.
  typedef struct packed {
    logic signed [CoeffW-1:0] low_coeff;
    logic signed [CoeffW-1:0] high_coeff;
  } in_t;

  // One result item.
  typedef struct packed {
    logic signed [CoeffW-1:0] even_sample;
    logic signed [CoeffW-1:0] odd_sample;
    logic                     row_end;
  } out_t;

  // Four filter taps: t0 weights the high coefficient, t1..t3 the lows.
  typedef struct packed {
    logic signed [4:0] t0;
    logic signed [4:0] t1;
    logic signed [4:0] t2;
    logic signed [4:0] t3;
  } tap_t;

  localparam tap_t TapFirstEven = '{t0: 5'sd1,  t1: 5'sd11, t2: -5'sd4, t3: 5'sd1};
  localparam tap_t TapFirstOdd  = '{t0: -5'sd1, t1: 5'sd5,  t2: 5'sd4,  t3: -5'sd1};
  localparam tap_t TapMidEven   = '{t0: 5'sd1,  t1: 5'sd1,  t2: 5'sd8,  t3: -5'sd1};
  localparam tap_t TapMidOdd    = '{t0: -5'sd1, t1: -5'sd1, t2: 5'sd8,  t3: 5'sd1};
  localparam tap_t TapLastEven  = '{t0: 5'sd1,  t1: -5'sd1, t2: 5'sd4,  t3: 5'sd5};
  localparam tap_t TapLastOdd   = '{t0: -5'sd1, t1: 5'sd1,  t2: -5'sd4, t3: 5'sd11};

  // One output sample. Taps are always constants, so the products fold
  // into a few shifted adds.
  function automatic logic signed [CoeffW-1:0] synth(
    input tap_t                     t,
    input logic signed [CoeffW-1:0] h,
    input logic signed [CoeffW-1:0] a,
    input logic signed [CoeffW-1:0] b,
    input logic signed [CoeffW-1:0] d,
    input logic [1:0]               shift,
    input logic                     clamp
  );
    logic signed [ExtW-1:0] lows;
    logic signed [ExtW-1:0] total;
    logic signed [ExtW-1:0] half;
    lows  = ExtW'(t.t1) * ExtW'(a) + ExtW'(t.t2) * ExtW'(b) + ExtW'(t.t3) * ExtW'(d);
    total = ExtW'(t.t0) * ExtW'(h) + ((lows + ExtW'(4)) >>> 3);
    total = total <<< shift;
    half  = total >>> 1;
    if (clamp) begin
      if (half < 0) begin
        half = '0;
      end else if (half > ExtW'((1 << ClampBits) - 1)) begin
        half = ExtW'((1 << ClampBits) - 1);
      end
    end
    return half[CoeffW-1:0];
  endfunction

endpackage

[sv/inverse_wavelet_row_synthesis_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse wavelet row synthesis core
// Horizontal inverse 2/6 wavelet pass over one row of low/high coefficient
// pairs, producing reconstructed even/odd sample pairs.
// ----------------------------------------------------------------------------
// The core accepts one coefficient item per clock cycle while in_stall_o is
// low. Each item is taken into an input register together with the
// coefficient history it needs, and the filter adds for up to two columns
// are then written into a four-entry result buffer once it has room. The
// first two items of a row give no result, the third and the last give two
// pairs, all others one; the result side drains one pair per cycle, and the
// row's two idle items absorb the extra pairs, so the input keeps its full
// rate while the output is not stalled. The input stalls only when the
// result buffer cannot take the pending pairs. Configuration registers sit
// on an APB-style port at byte addresses 0, 4 and 8.
module inverse_wavelet_row_synthesis_core #(
  parameter int unsigned MAX_ROW_PAIRS = iwrs_pkg::MaxRowPairsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  iwrs_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output iwrs_pkg::out_t                 out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [iwrs_pkg::AddrW-1:0]     paddr,
  input  logic [iwrs_pkg::DataW-1:0]     pwdata,
  output logic [iwrs_pkg::DataW-1:0]     prdata,
  output logic                           pready
);
  import iwrs_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ROW_PAIRS);
  localparam int unsigned CmpW = ((CntW > RowWidthW) ? CntW : RowWidthW) + 1;

  // Configuration registers.
  logic [RowWidthW-1:0] row_w_q;
  logic [1:0]           shift_q;
  logic                 clamp_q;
  logic                 cfg_wr;

  // Row state.
  logic [CntW-1:0]          col_q, col_d;
  logic signed [CoeffW-1:0] lo0_q, lo1_q;
  logic signed [CoeffW-1:0] hi0_q, hi1_q;

  // Input register stage.
  logic                     s1_valid_q, s1_valid_d;
  mode_e                    s1_mode_q, s1_mode_d;
  logic [1:0]               s1_cnt_q, s1_cnt_d;
  logic signed [CoeffW-1:0] s1_a_q, s1_b_q, s1_d_q;
  logic signed [CoeffW-1:0] s1_h0_q, s1_h0_d, s1_h1_q, s1_h1_d;
  logic                     s1_adv;

  // Result buffer.
  out_t                 fifo_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]  fifo_cnt_q, fifo_cnt_d;
  logic [1:0]           push_n;
  logic                 pop;
  out_t                 res0, res1;

  logic            in_accept;
  logic            in_last;
  logic [CmpW-1:0] w_raw, w_eff;

  // Configuration port: always ready, written on the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_w_q <= RowWidthW'(MaxRowPairsDefault);
      shift_q <= '0;
      clamp_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(paddr[AddrW-1:2]))
        REG_ROW_HALF_WIDTH: row_w_q <= pwdata[RowWidthW-1:0];
        REG_DESCALE_SHIFT:  shift_q <= pwdata[1:0];
        REG_CLAMP_ENABLE:   clamp_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_e'(paddr[AddrW-1:2]))
      REG_ROW_HALF_WIDTH: prdata = DataW'(row_w_q);
      REG_DESCALE_SHIFT:  prdata = DataW'(shift_q);
      REG_CLAMP_ENABLE:   prdata = DataW'(clamp_q);
      default:            prdata = '0;
    endcase
  end

  // Effective row width, limited to the supported range.
  assign w_raw = CmpW'(row_w_q);
  always_comb begin
    if (w_raw < CmpW'(MinRowPairs)) begin
      w_eff = CmpW'(MinRowPairs);
    end else if (w_raw > CmpW'(MAX_ROW_PAIRS)) begin
      w_eff = CmpW'(MAX_ROW_PAIRS);
    end else begin
      w_eff = w_raw;
    end
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_last   = (CmpW'(col_q) + CmpW'(1)) >= w_eff;

  // Column position decides which taps and high coefficients each pair uses.
  always_comb begin
    s1_mode_d = MODE_MID;
    s1_cnt_d  = 2'd0;
    s1_h0_d   = hi0_q;
    s1_h1_d   = hi0_q;
    if (in_last) begin
      s1_mode_d = MODE_LAST;
      s1_cnt_d  = 2'd2;
      s1_h1_d   = in_data_i.high_coeff;
    end else if (col_q == CntW'(2)) begin
      s1_mode_d = MODE_FIRST;
      s1_cnt_d  = 2'd2;
      s1_h0_d   = hi1_q;
    end else if (col_q > CntW'(2)) begin
      s1_cnt_d  = 2'd1;
    end
    col_d = in_last ? '0 : col_q + CntW'(1);
  end

  // Stage handshake: the input register moves on once the buffer has room.
  assign s1_adv     = s1_valid_q && ((FifoCntW'(s1_cnt_q) + fifo_cnt_q) <= FifoCntW'(FifoDepth));
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign s1_valid_d = in_accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      lo0_q      <= '0;
      lo1_q      <= '0;
      hi0_q      <= '0;
      hi1_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_accept) begin
        col_q <= col_d;
        lo1_q <= lo0_q;
        lo0_q <= in_data_i.low_coeff;
        hi1_q <= hi0_q;
        hi0_q <= in_data_i.high_coeff;
      end
    end
  end

  // Operands of the accepted item.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q <= s1_mode_d;
      s1_cnt_q  <= s1_cnt_d;
      s1_a_q    <= lo1_q;
      s1_b_q    <= lo0_q;
      s1_d_q    <= in_data_i.low_coeff;
      s1_h0_q   <= s1_h0_d;
      s1_h1_q   <= s1_h1_d;
    end
  end

  // Filter arithmetic for both pairs of the registered item.
  always_comb begin
    if (s1_mode_q == MODE_FIRST) begin
      res0.even_sample = synth(TapFirstEven, s1_h0_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
      res0.odd_sample  = synth(TapFirstOdd, s1_h0_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
    end else begin
      res0.even_sample = synth(TapMidEven, s1_h0_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
      res0.odd_sample  = synth(TapMidOdd, s1_h0_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
    end
    res0.row_end = 1'b0;
    if (s1_mode_q == MODE_LAST) begin
      res1.even_sample = synth(TapLastEven, s1_h1_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
      res1.odd_sample  = synth(TapLastOdd, s1_h1_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
      res1.row_end     = 1'b1;
    end else begin
      res1.even_sample = synth(TapMidEven, s1_h1_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
      res1.odd_sample  = synth(TapMidOdd, s1_h1_q, s1_a_q, s1_b_q, s1_d_q,
                               shift_q, clamp_q);
      res1.row_end     = 1'b0;
    end
  end

  // Result buffer bookkeeping: up to two pushes and one pop per cycle.
  assign push_n      = s1_adv ? s1_cnt_q : 2'd0;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign fifo_cnt_d  = fifo_cnt_q + FifoCntW'(push_n) - FifoCntW'(pop);
  assign out_data_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + FifoPtrW'(push_n);
      rd_ptr_q   <= rd_ptr_q + FifoPtrW'(pop);
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + FifoPtrW'(1)] <= res1;
    end
  end

  // The buffer never holds more items than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= FifoCntW'(FifoDepth))
    else $error("result buffer overfilled");

  // A held input register means the buffer lacks room for two pairs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (fifo_cnt_q > FifoCntW'(FifoDepth - 2)))
    else $error("input register held with buffer space free");

  // The row's last item starts the next row at column zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_last) |=> (col_q == '0))
    else $error("column counter did not wrap at row end");

  // A delivered item with nothing pushed shrinks the buffer by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (push_n == 2'd0)) |=> (fifo_cnt_q == $past(fifo_cnt_q) - FifoCntW'(1)))
    else $error("result buffer count mismatch");

endmodule

[bench/inverse_wavelet_row_synthesis_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse wavelet row synthesis core testbench
// Sends coefficient items through the core under random input gaps and
// output stalls. A directed table covers register reset values, saturated
// rows, out-of-range widths and a width change in the middle of a row. Random
// phases with fresh register settings follow. Every result item is checked
// against the in-bench filter model, or typed rows against table values.
// ----------------------------------------------------------------------------
module inverse_wavelet_row_synthesis_core_test;

  import iwrs_pkg::*;

  localparam int          RowPairsMax   = MaxRowPairsDefault;
  localparam int          SettleCycles  = 8;
  localparam int          CycleLimit    = 400000;
  localparam int          RandomItems   = 1450;
  localparam longint      SampleCeiling = (1 << ClampBits) - 1;
  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [1:0]  RegUnused     = 2'd3;

  typedef enum logic [1:0] {
    STEP_WRITE,
    STEP_READ,
    STEP_ITEM
  } step_kind_e;

  typedef enum logic [1:0] {
    COL_FIRST,
    COL_MID,
    COL_LAST
  } col_kind_e;

  // One row of the directed table.
  typedef struct {
    step_kind_e  kind;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    in_t         item;
    bit          typed;
    logic [15:0] even_val;
    logic [15:0] odd_val;
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic        pready;

  // Model state and register copies.
  logic signed [15:0] low_hist [3];
  logic signed [15:0] high_hist [2];
  logic [12:0]        col_pos;
  logic [12:0]        row_pairs_cfg;
  logic [1:0]         shift_cfg;
  logic               clamp_cfg;

  out_t   pending_pairs [$];
  step_t  plan [$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  bit     steady = 1'b0;

  inverse_wavelet_row_synthesis_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Random output stalls, off during the steady stretch.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall <= !steady && ($urandom_range(99) < 15);
    end
  end

  // One output sample of the filter.
  function automatic logic signed [15:0] synth_sample(int t0, int t1, int t2, int t3,
                                                      longint h, longint a, longint b,
                                                      longint d);
    longint lows;
    longint total;
    lows  = t1 * a + t2 * b + t3 * d;
    total = t0 * h + ((lows + 4) >>> 3);
    total = total <<< shift_cfg;
    total = total >>> 1;
    if (clamp_cfg) begin
      if (total < 0) begin
        total = 0;
      end else if (total > SampleCeiling) begin
        total = SampleCeiling;
      end
    end
    return total[15:0];
  endfunction

  // Even/odd pair of one column from the current low history.
  function automatic out_t column_pair(col_kind_e kind, longint h, logic tail);
    int   te [4];
    int   to [4];
    out_t r;
    case (kind)
      COL_FIRST: begin
        te = '{1, 11, -4, 1};
        to = '{-1, 5, 4, -1};
      end
      COL_LAST: begin
        te = '{1, -1, 4, 5};
        to = '{-1, 1, -4, 11};
      end
      default: begin
        te = '{1, 1, 8, -1};
        to = '{-1, -1, 8, 1};
      end
    endcase
    r.even_sample = synth_sample(te[0], te[1], te[2], te[3], h,
                                 low_hist[2], low_hist[1], low_hist[0]);
    r.odd_sample  = synth_sample(to[0], to[1], to[2], to[3], h,
                                 low_hist[2], low_hist[1], low_hist[0]);
    r.row_end     = tail;
    return r;
  endfunction

  // Advance the model by one accepted item and queue the pairs it yields.
  // Typed rows replace the computed samples by the values from the table.
  task automatic predict_item(input in_t it, input bit typed,
                              input logic [15:0] even_val, input logic [15:0] odd_val);
    int   w;
    bit   last;
    out_t fresh [$];
    w = row_pairs_cfg;
    if (w < MinRowPairs) begin
      w = MinRowPairs;
    end
    if (w > RowPairsMax) begin
      w = RowPairsMax;
    end
    last = (int'(col_pos) + 1 >= w);
    low_hist[2] = low_hist[1];
    low_hist[1] = low_hist[0];
    low_hist[0] = it.low_coeff;
    if (last) begin
      fresh.push_back(column_pair(COL_MID, high_hist[0], 1'b0));
      fresh.push_back(column_pair(COL_LAST, $signed(it.high_coeff), 1'b1));
    end else if (col_pos == 13'd2) begin
      fresh.push_back(column_pair(COL_FIRST, high_hist[1], 1'b0));
      fresh.push_back(column_pair(COL_MID, high_hist[0], 1'b0));
    end else if (col_pos > 13'd2) begin
      fresh.push_back(column_pair(COL_MID, high_hist[0], 1'b0));
    end
    high_hist[1] = high_hist[0];
    high_hist[0] = it.high_coeff;
    col_pos = last ? 13'd0 : col_pos + 13'd1;
    foreach (fresh[k]) begin
      if (typed) begin
        fresh[k].even_sample = even_val;
        fresh[k].odd_sample  = odd_val;
      end
      pending_pairs.push_back(fresh[k]);
    end
  endtask

  // Send one item; entered and left at a falling edge.
  task automatic push_item(input in_t it, input bit typed,
                           input logic [15:0] even_val, input logic [15:0] odd_val);
    while (!steady && ($urandom_range(99) < 15)) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do begin
      @(posedge clk_i);
    end while (in_stall);
    predict_item(it, typed, even_val, odd_val);
    @(negedge clk_i);
  endtask

  // Wait until all results are out and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register access; a write updates the model's register copy.
  task automatic reg_access(input bit wr, input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wr ? val : 32'd0;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (wr) begin
      case (idx)
        REG_ROW_HALF_WIDTH: row_pairs_cfg = val[12:0];
        REG_DESCALE_SHIFT:  shift_cfg = val[1:0];
        REG_CLAMP_ENABLE:   clamp_cfg = val[0];
        default: ;
      endcase
    end else if (prdata !== val) begin
      $error("register %0d expected %0d got %0d", idx, val, prdata);
      mismatch_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic add_write(input logic [1:0] idx, input logic [31:0] val);
    step_t s;
    s = '{kind: STEP_WRITE, reg_idx: idx, reg_val: val, item: '0, typed: 1'b0,
          even_val: '0, odd_val: '0};
    plan.push_back(s);
  endtask

  task automatic add_read(input logic [1:0] idx, input logic [31:0] val);
    step_t s;
    s = '{kind: STEP_READ, reg_idx: idx, reg_val: val, item: '0, typed: 1'b0,
          even_val: '0, odd_val: '0};
    plan.push_back(s);
  endtask

  task automatic add_items(input int count, input logic [15:0] lo, input logic [15:0] hi,
                           input bit typed, input logic [15:0] even_val,
                           input logic [15:0] odd_val);
    step_t s;
    s.kind     = STEP_ITEM;
    s.reg_idx  = '0;
    s.reg_val  = '0;
    s.item.low_coeff  = lo;
    s.item.high_coeff = hi;
    s.typed    = typed;
    s.even_val = even_val;
    s.odd_val  = odd_val;
    repeat (count) plan.push_back(s);
  endtask

  // Coefficient mix: extremes, values near zero, and full-range noise.
  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(9))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // Compare each accepted result with the oldest pending pair.
  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("result item with nothing pending: even %0d odd %0d end %0b",
               $signed(out_data.even_sample), $signed(out_data.odd_sample),
               out_data.row_end);
        mismatch_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (out_data.even_sample !== want.even_sample) begin
          $error("even_sample expected %0d got %0d",
                 $signed(want.even_sample), $signed(out_data.even_sample));
          mismatch_count++;
        end
        if (out_data.odd_sample !== want.odd_sample) begin
          $error("odd_sample expected %0d got %0d",
                 $signed(want.odd_sample), $signed(out_data.odd_sample));
          mismatch_count++;
        end
        if (out_data.row_end !== want.row_end) begin
          $error("row_end expected %0b got %0b", want.row_end, out_data.row_end);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin : stimulus
    int          sent;
    int          phase;
    int          count;
    int          w;
    logic [31:0] val;
    in_t         it;

    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    row_pairs_cfg = 13'd4096;
    shift_cfg     = 2'd0;
    clamp_cfg     = 1'b0;
    low_hist      = '{default: '0};
    high_hist     = '{default: '0};
    col_pos       = '0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values, then constant rows at both extremes, with and without
    // clamping. A constant row reconstructs to the constant on even columns
    // and zero on odd ones; clamping limits even samples to 0..16383.
    add_read(REG_ROW_HALF_WIDTH, 32'd4096);
    add_read(REG_DESCALE_SHIFT, 32'd0);
    add_read(REG_CLAMP_ENABLE, 32'd0);
    add_write(REG_ROW_HALF_WIDTH, 32'd4);
    add_write(REG_DESCALE_SHIFT, 32'd0);
    add_write(REG_CLAMP_ENABLE, 32'd0);
    add_items(4, 16'h7fff, 16'h7fff, 1'b1, 16'h7fff, 16'h0000);
    add_items(4, 16'h8000, 16'h8000, 1'b1, 16'h8000, 16'h0000);
    add_write(REG_CLAMP_ENABLE, 32'd1);
    add_items(4, 16'h7fff, 16'h7fff, 1'b1, 16'h3fff, 16'h0000);
    add_items(4, 16'h8000, 16'h8000, 1'b1, 16'h0000, 16'h0000);
    // Descale of three and a width below the minimum.
    add_write(REG_CLAMP_ENABLE, 32'd0);
    add_write(REG_DESCALE_SHIFT, 32'd3);
    add_write(REG_ROW_HALF_WIDTH, 32'd2);
    add_read(REG_ROW_HALF_WIDTH, 32'd2);
    add_items(1, 16'h1234, 16'hfedc, 1'b0, '0, '0);
    add_items(1, 16'h7fff, 16'h8000, 1'b0, '0, '0);
    add_items(1, 16'h8000, 16'h7fff, 1'b0, '0, '0);
    add_items(1, 16'h0001, 16'hffff, 1'b0, '0, '0);
    // Width above the maximum, an unknown register, then a width cut short
    // in the middle of a row so the next item closes it.
    add_write(REG_ROW_HALF_WIDTH, 32'd8191);
    add_read(REG_ROW_HALF_WIDTH, 32'd8191);
    add_write(RegUnused, 32'hffff_ffff);
    add_items(1, 16'h0100, 16'h0010, 1'b0, '0, '0);
    add_items(1, 16'hff00, 16'h0f0f, 1'b0, '0, '0);
    add_items(1, 16'h5555, 16'haaaa, 1'b0, '0, '0);
    add_write(REG_ROW_HALF_WIDTH, 32'd4);
    add_write(REG_DESCALE_SHIFT, 32'd2);
    add_items(1, 16'haaaa, 16'h5555, 1'b0, '0, '0);

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_WRITE: begin
          settle();
          reg_access(1'b1, plan[i].reg_idx, plan[i].reg_val);
        end
        STEP_READ: begin
          settle();
          reg_access(1'b0, plan[i].reg_idx, plan[i].reg_val);
        end
        default: begin
          push_item(plan[i].item, plan[i].typed, plan[i].even_val, plan[i].odd_val);
        end
      endcase
    end

    // Random phases, each with fresh register settings. Phases often end
    // in the middle of a row, so later widths cut rows short.
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      settle();
      steady = (phase >= 6 && phase <= 8);
      if (phase == 0) begin
        w = MinRowPairs;
      end else begin
        case ($urandom_range(9))
          0:       w = MinRowPairs;
          1:       w = $urandom_range(3);
          2:       w = $urandom_range(8191, RowPairsMax + 1);
          3:       w = $urandom_range(8, 5);
          default: w = $urandom_range(40, 4);
        endcase
      end
      val = $urandom;
      val[12:0] = w[12:0];
      reg_access(1'b1, REG_ROW_HALF_WIDTH, val);
      val = $urandom;
      val[1:0] = (phase < 4) ? phase[1:0] : 2'($urandom_range(3));
      reg_access(1'b1, REG_DESCALE_SHIFT, val);
      val = $urandom;
      val[0] = (phase < 4) ? phase[0] : 1'($urandom_range(1));
      reg_access(1'b1, REG_CLAMP_ENABLE, val);
      count = $urandom_range(120, 10);
      repeat (count) begin
        it.low_coeff  = pick_coeff();
        it.high_coeff = pick_coeff();
        push_item(it, 1'b0, '0, '0);
      end
      sent += count;
      phase++;
    end
    steady = 1'b0;

    settle();
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
